// ===== hdl/ppc_branch_relocator_assert.svh =====
// assertion macros used by the relocator checker
`ifndef PPC_BRANCH_RELOCATOR_ASSERT_SVH
`define PPC_BRANCH_RELOCATOR_ASSERT_SVH

// clocked assertion, masked while reset is active
`define PBR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("relocator assertion failed");

// clocked assertion that is also checked through reset
`define PBR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("relocator assertion failed during reset");

`endif

// ===== hdl/ppcbr_pkg.sv =====
`timescale 1ns / 1ps
package ppcbr_pkg;

  // primary opcodes
  localparam logic [5:0] OP_BC    = 6'd16;
  localparam logic [5:0] OP_B     = 6'd18;
  localparam logic [5:0] OP_LIS   = 6'd15;
  localparam logic [5:0] OP_XL    = 6'd19;
  localparam logic [5:0] OP_ORI   = 6'd24;
  localparam logic [5:0] OP_EXT31 = 6'd31;
  localparam logic [5:0] OP_LD    = 6'd58;
  localparam logic [5:0] OP_STD   = 6'd62;

  // fixed fields
  localparam logic [4:0]  BO_ALWAYS = 5'd20;
  localparam logic [4:0]  REG_R0    = 5'd0;
  localparam logic [4:0]  REG_SP    = 5'd1;
  localparam logic [15:0] FRAME_DS  = 16'hFFD0;
  localparam logic [9:0]  XO_BCCTR  = 10'd528;
  localparam logic [9:0]  XO_MTSPR  = 10'd467;
  localparam logic [9:0]  SPR_CTR   = 10'd288;

  // sequence step counter
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP_KEEP = 3'd5;
  localparam logic [STEP_W-1:0] LAST_STEP_FAST = 3'd3;

  typedef enum logic [0:0] {
    KIND_PASS = 1'b0,
    KIND_FAR  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    SLOT_STD   = 3'd0,
    SLOT_LIS   = 3'd1,
    SLOT_ORI   = 3'd2,
    SLOT_MTCTR = 3'd3,
    SLOT_LD    = 3'd4,
    SLOT_BCCTR = 3'd5
  } slot_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] instr_word;
    logic [31:0] address;
    logic        link_flag;
    logic        keep_register;
  } in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        last_word;
  } out_t;

  // classified work handed from front to back; target holds the word on pass
  typedef struct packed {
    kind_e       kind;
    logic        keep;
    logic [31:0] target;
    logic [4:0]  bo;
    logic [4:0]  bi;
    logic        lk;
  } desc_t;

  function automatic logic [31:0] mk_dform(logic [5:0] op, logic [4:0] rt,
                                           logic [4:0] ra, logic [15:0] low);
    return {op, rt, ra, low};
  endfunction

  // which instruction a step stands for
  function automatic slot_e slot_of(logic [STEP_W-1:0] step, logic keep);
    slot_e s;
    s = SLOT_BCCTR;
    if (keep) begin
      s = slot_e'(step);
    end else begin
      unique case (step)
        3'd0:    s = SLOT_LIS;
        3'd1:    s = SLOT_ORI;
        3'd2:    s = SLOT_MTCTR;
        default: s = SLOT_BCCTR;
      endcase
    end
    return s;
  endfunction

  // one word of the far branch sequence
  function automatic logic [31:0] far_word(slot_e slot, desc_t d);
    logic [31:0] w;
    w = '0;
    unique case (slot)
      SLOT_STD:   w = mk_dform(OP_STD, REG_R0, REG_SP, FRAME_DS);
      SLOT_LIS:   w = mk_dform(OP_LIS, REG_R0, REG_R0, d.target[31:16]);
      SLOT_ORI:   w = mk_dform(OP_ORI, REG_R0, REG_R0, d.target[15:0]);
      SLOT_MTCTR: w = {OP_EXT31, REG_R0, SPR_CTR, XO_MTSPR, 1'b0};
      SLOT_LD:    w = mk_dform(OP_LD, REG_R0, REG_SP, FRAME_DS);
      SLOT_BCCTR: w = {OP_XL, d.bo, d.bi, 5'd0, XO_BCCTR, d.lk};
      default:    w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/ppcbr_front.sv =====
`timescale 1ns / 1ps
module ppcbr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ppcbr_pkg::in_t   in_data_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output ppcbr_pkg::desc_t push_desc_o
);
  import ppcbr_pkg::*;

  logic        valid_q, valid_d;
  desc_t       desc_q, desc_d;
  logic [5:0]  op;
  logic        is_b, is_bc;
  logic [31:0] disp;
  logic        load;

  // stage register frees when the queue takes its word
  assign in_ready_o = !valid_q || push_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // decode the incoming word
  assign op    = in_data_i.instr_word[31:26];
  assign is_b  = (op == OP_B)  && !in_data_i.instr_word[1];
  assign is_bc = (op == OP_BC) && !in_data_i.instr_word[1];

  // sign-extended displacement
  always_comb begin
    if (is_b) begin
      disp = {{6{in_data_i.instr_word[25]}}, in_data_i.instr_word[25:2], 2'b00};
    end else begin
      disp = {{16{in_data_i.instr_word[15]}}, in_data_i.instr_word[15:2], 2'b00};
    end
  end

  // classify into a descriptor
  always_comb begin
    desc_d = desc_q;
    if (load) begin
      if (in_data_i.cmd) begin
        desc_d.kind   = KIND_FAR;
        desc_d.keep   = in_data_i.keep_register;
        desc_d.target = in_data_i.address;
        desc_d.bo     = BO_ALWAYS;
        desc_d.bi     = REG_R0;
        desc_d.lk     = in_data_i.link_flag;
      end else if (is_b || is_bc) begin
        desc_d.kind   = KIND_FAR;
        desc_d.keep   = 1'b1;
        desc_d.target = in_data_i.address + disp;
        desc_d.bo     = is_b ? BO_ALWAYS : in_data_i.instr_word[25:21];
        desc_d.bi     = is_b ? REG_R0 : in_data_i.instr_word[20:16];
        desc_d.lk     = in_data_i.instr_word[0];
      end else begin
        desc_d.kind   = KIND_PASS;
        desc_d.keep   = 1'b0;
        desc_d.target = in_data_i.instr_word;
        desc_d.bo     = '0;
        desc_d.bi     = '0;
        desc_d.lk     = 1'b0;
      end
    end
  end

  // valid tracking
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign push_valid_o = valid_q;
  assign push_desc_o  = desc_q;

endmodule

// ===== hdl/ppcbr_queue.sv =====
`timescale 1ns / 1ps
module ppcbr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  ppcbr_pkg::desc_t push_desc_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output ppcbr_pkg::desc_t pop_desc_o
);
  import ppcbr_pkg::*;

  desc_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_desc_o   = mem_q[rptr_q];

  // pointer and fill update
  always_comb begin
    wptr_d  = push ? !wptr_q : wptr_q;
    rptr_d  = pop ? !rptr_q : rptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_desc_i;
    end
  end

endmodule

// ===== hdl/ppcbr_back.sv =====
`timescale 1ns / 1ps
module ppcbr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  ppcbr_pkg::desc_t head_desc_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ppcbr_pkg::out_t  out_data_o
);
  import ppcbr_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] last_step;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic              load;
  logic              is_last;

  // output register can take a new word
  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  // length of the current sequence
  always_comb begin
    if (head_desc_i.kind == KIND_PASS) begin
      last_step = '0;
    end else if (head_desc_i.keep) begin
      last_step = LAST_STEP_KEEP;
    end else begin
      last_step = LAST_STEP_FAST;
    end
  end

  assign is_last = (step_q == last_step);
  assign pop_o   = load && is_last;

  // next word and step
  always_comb begin
    out_d       = out_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d     = 1'b1;
      out_d.last_word = is_last;
      if (head_desc_i.kind == KIND_PASS) begin
        out_d.out_word = head_desc_i.target;
      end else begin
        out_d.out_word = far_word(slot_of(step_q, head_desc_i.keep), head_desc_i);
      end
      step_d = is_last ? '0 : step_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/ppc_branch_relocator.sv =====
// an item passes the decode register, the queue and the output register
// throughput: one word per cycle from the output sequencer while not stalled;
//   an item is 1 word (pass-through), 4 (short far branch) or 6 (saved r0)
// a two-entry queue between decode and sequencer lets input run ahead of output
// reset: asynchronous active low, empties the stage, queue and output register
`timescale 1ns / 1ps
module ppc_branch_relocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ppcbr_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ppcbr_pkg::out_t out_data_o
);
  import ppcbr_pkg::*;

  logic  push_valid, push_ready;
  desc_t push_desc;
  logic  head_valid, pop;
  desc_t head_desc;

  // decode and target add
  ppcbr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc)
  );

  // decoupling queue
  ppcbr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_desc_o   (head_desc)
  );

  // word sequencer
  ppcbr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hdl/ppcbr_checker.sv =====
`timescale 1ns / 1ps
`include "ppc_branch_relocator_assert.svh"
module ppcbr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input ppcbr_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input ppcbr_pkg::out_t out_data_o
);
  import ppcbr_pkg::*;

  logic       in_stall;
  logic       out_stall;
  logic       mid_take;
  logic [5:0] out_op;

  // handshake shorthands
  assign in_stall  = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign mid_take  = out_valid_o && out_ready_i && !out_data_o.last_word;
  assign out_op    = out_data_o.out_word[31:26];

  // a waiting input word holds
  `PBR_ASSERT(a_in_hold, clk_i, rst_ni, in_stall |=> in_valid_i && $stable(in_data_i))

  // a stalled word holds
  `PBR_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_data_o))

  // a sequence streams without gaps until its last word
  `PBR_ASSERT(a_seq_gapless, clk_i, rst_ni, mid_take |=> out_valid_o)

  // inside a sequence lis is followed by ori
  `PBR_ASSERT(a_lis_ori, clk_i, rst_ni, mid_take && out_op == OP_LIS |=> out_op == OP_ORI)

  // nothing is shown right out of reset
  `PBR_ASSERT_ALWAYS(a_reset_idle, clk_i, $rose(rst_ni) |-> !out_valid_o)

endmodule

bind ppc_branch_relocator ppcbr_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
